// File: rtl/iopt_pkg.sv
// Shared types, widths and codes for the item offset prefix table.
`default_nettype none
package iopt_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int IDX_W      = $clog2(MAX_ITEMS + 1);
  localparam int DEPTH      = MAX_ITEMS + 1;
  localparam int OFF_W      = 32;
  localparam int HEIGHT_W   = 16;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int DIV_STEPS  = OFF_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = HEIGHT_W;

  localparam int IN_BITS  = CMD_W + 2 * IDX_W + HEIGHT_W + 2 * OFF_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + 3 * OFF_W + 2 * IDX_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_VARIABLE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_HEIGHT  = 1'd1;
  localparam logic [HEIGHT_W-1:0]  FIXED_HEIGHT_RST  = 16'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_QUERY  = 3'd4,
    CMD_RANGE  = 3'd5,
    CMD_TOTAL  = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_INDEX   = 3'd1,
    ST_BAD_COUNT   = 3'd2,
    ST_FULL        = 3'd3,
    ST_ZERO_HEIGHT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PATH_DONE,
    PATH_INS,
    PATH_PAIR,
    PATH_SRCH,
    PATH_DIV
  } path_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_PAIR0,
    OP_PAIR1,
    OP_PAIR_END,
    OP_LOOP,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_S1_END,
    OP_S2_END,
    OP_DIV_STEP,
    OP_DIV_MID,
    OP_DIV_END,
    OP_TOT_RD,
    OP_TOT_CAP
  } dp_op_t;

  typedef struct packed {
    logic  emit;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    path_t path;
    logic  pair_loop;
    logic  loop_done;
    logic  srch_more;
    logic  srch_hit;
    logic  div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/iopt_dp.sv
// Datapath: offset table memory, loop walker, binary search, divider, result registers.
`default_nettype none
module iopt_dp import iopt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic [IN_W-1:0]       in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_W-1:0]           out_data
);

  // captured command
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]    idx_q, span_q;
  logic [HEIGHT_W-1:0] h_q;
  logic [OFF_W-1:0]    rb_q, re_q;

  logic                variable_mode;
  logic [HEIGHT_W-1:0] fixed_height;
  logic [IDX_W-1:0]    items;

  logic [OFF_W-1:0] mem [DEPTH];
  logic [OFF_W-1:0] rdata;
  logic             rd_zero;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr;
  logic [OFF_W-1:0] rd_val;

  logic [IDX_W-1:0] rptr, rlast, wptr;
  logic             rd_more, rd_live, dir_up;
  logic [OFF_W-1:0] addend, base;

  logic [IDX_W-1:0] lo, hi, mid, mid_q;
  logic [OFF_W-1:0] key;
  logic             strict, go_right;

  logic [DIV_CNT_W-1:0] div_cnt;
  logic [HEIGHT_W-1:0]  div_rem;
  logic [DIV_STEPS-1:0] div_q, dividend2;
  logic [OFF_W-1:0]     bi;
  logic [HEIGHT_W:0]    r2;
  logic                 r2_ge;

  logic [STATUS_W-1:0] res_status;
  logic [OFF_W-1:0]    res_off, res_h, res_total;
  logic [IDX_W-1:0]    res_first, res_cnt;

  status_t          ex_status;
  path_t            ex_path;
  logic [IDX_W-1:0] items_p1, pair_addr, hit_first;
  logic [IDX_W:0]   ins_sum;
  logic [OFF_W-1:0] pair_h;
  logic [HEIGHT_W+IDX_W-1:0] idx_prod, items_prod;

  assign rd_val    = rd_zero ? '0 : rdata;
  assign items_p1  = items + IDX_W'(1);
  assign ins_sum   = {1'b0, items} + {1'b0, span_q};
  assign pair_addr = idx_q + ((cmd_q == CMD_REMOVE) ? span_q : IDX_W'(1));
  assign pair_h    = rd_val - base;
  assign mid       = lo + ((hi - lo) >> 1);
  assign go_right  = strict ? (rd_val <= key) : (rd_val < key);
  assign r2        = {div_rem, div_q[DIV_STEPS-1]};
  assign r2_ge     = r2 >= {1'b0, fixed_height};
  assign dividend2 = {1'b0, re_q} + {{(DIV_STEPS-HEIGHT_W){1'b0}}, fixed_height}
                     - DIV_STEPS'(1);
  assign idx_prod   = idx_q * fixed_height;
  assign items_prod = items * fixed_height;
  assign hit_first  = lo - IDX_W'(1);

  // command check
  always_comb begin
    ex_status = ST_OK;
    ex_path   = PATH_DONE;
    case (cmd_q)
      CMD_INSERT: begin
        if (idx_q > items) ex_status = ST_BAD_INDEX;
        else if (variable_mode) begin
          if (items == IDX_W'(MAX_ITEMS)) ex_status = ST_FULL;
          else ex_path = PATH_INS;
        end else if (ins_sum > (IDX_W+1)'(MAX_ITEMS)) ex_status = ST_FULL;
      end
      CMD_REMOVE: begin
        if (idx_q >= items) ex_status = ST_BAD_INDEX;
        else if (span_q > items - idx_q) ex_status = ST_BAD_COUNT;
        else if (variable_mode && span_q != '0) ex_path = PATH_PAIR;
      end
      CMD_UPDATE, CMD_QUERY: begin
        if (idx_q >= items) ex_status = ST_BAD_INDEX;
        else if (variable_mode) ex_path = PATH_PAIR;
      end
      CMD_RANGE: begin
        if (rb_q <= re_q) begin
          if (variable_mode) ex_path = PATH_SRCH;
          else if (fixed_height == '0) ex_status = ST_ZERO_HEIGHT;
          else ex_path = PATH_DIV;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.path      = ex_path;
    stat.pair_loop = cmd_q != CMD_QUERY;
    stat.loop_done = !rd_more && !rd_live;
    stat.srch_more = lo < hi;
    stat.srch_hit  = (lo != '0) && (lo != items_p1);
    stat.div_done  = div_cnt == '0;
  end

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = items;
    case (cmd.op)
      OP_LOOP: begin
        rd_en   = rd_more;
        rd_addr = rptr;
      end
      OP_PAIR0: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
      end
      OP_PAIR1: begin
        rd_en   = 1'b1;
        rd_addr = pair_addr;
      end
      OP_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid;
      end
      OP_TOT_RD: rd_en = 1'b1;
      default: ;
    endcase
  end

  assign wr_en = (cmd.op == OP_LOOP) && rd_live;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= rd_val + addend;
    if (rd_en) begin
      rdata   <= mem[rd_addr];
      rd_zero <= rd_addr == '0;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      variable_mode <= 1'b0;
      fixed_height  <= FIXED_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VARIABLE_MODE: variable_mode <= cfg_data[0];
        CFG_FIXED_HEIGHT:  fixed_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control-type state
  always_ff @(posedge clk) begin
    if (rst) begin
      items   <= '0;
      rd_more <= 1'b0;
      rd_live <= 1'b0;
      div_cnt <= '0;
    end else begin
      case (cmd.op)
        OP_EXEC: begin
          case (cmd_q)
            CMD_CLEAR: items <= '0;
            CMD_INSERT: begin
              if (ex_status == ST_OK) begin
                if (variable_mode) begin
                  items   <= items_p1;
                  rd_more <= 1'b1;
                  rd_live <= 1'b0;
                end else begin
                  items <= ins_sum[IDX_W-1:0];
                end
              end
            end
            CMD_REMOVE: begin
              if (ex_status == ST_OK && ex_path == PATH_DONE) items <= items - span_q;
            end
            default: ;
          endcase
          if (ex_path == PATH_DIV) div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end
        OP_PAIR_END: begin
          if (cmd_q != CMD_QUERY) begin
            rd_more <= 1'b1;
            rd_live <= 1'b0;
          end
          if (cmd_q == CMD_REMOVE) items <= items - span_q;
        end
        OP_LOOP: begin
          if (rd_more) rd_more <= rptr != rlast;
          rd_live <= rd_more;
        end
        OP_DIV_STEP: if (div_cnt != '0) div_cnt <= div_cnt - DIV_CNT_W'(1);
        OP_DIV_MID:  div_cnt <= DIV_CNT_W'(DIV_STEPS);
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_q  <= in_data[CMD_W-1:0];
        idx_q  <= in_data[CMD_W +: IDX_W];
        span_q <= in_data[CMD_W+IDX_W +: IDX_W];
        h_q    <= in_data[CMD_W+2*IDX_W +: HEIGHT_W];
        rb_q   <= in_data[CMD_W+2*IDX_W+HEIGHT_W +: OFF_W];
        re_q   <= in_data[CMD_W+2*IDX_W+HEIGHT_W+OFF_W +: OFF_W];
      end
      OP_EXEC: begin
        res_status <= ex_status;
        res_off    <= '0;
        res_h      <= '0;
        res_first  <= '0;
        res_cnt    <= '0;
        if (cmd_q == CMD_QUERY && ex_status == ST_OK && !variable_mode) begin
          res_h   <= {{(OFF_W-HEIGHT_W){1'b0}}, fixed_height};
          res_off <= {{(OFF_W-HEIGHT_W-IDX_W){1'b0}}, idx_prod};
        end
        // insert walks down: entry i takes entry i-1 plus the new height
        rptr   <= items;
        rlast  <= idx_q;
        wptr   <= items_p1;
        addend <= {{(OFF_W-HEIGHT_W){1'b0}}, h_q};
        dir_up <= 1'b0;
        lo     <= '0;
        hi     <= items_p1;
        key    <= rb_q;
        strict <= 1'b1;
        div_rem <= '0;
        div_q   <= {1'b0, rb_q};
      end
      OP_PAIR1: base <= rd_val;
      OP_PAIR_END: begin
        dir_up <= 1'b1;
        rlast  <= items;
        case (cmd_q)
          CMD_REMOVE: begin
            addend <= base - rd_val;
            rptr   <= idx_q + span_q;
            wptr   <= idx_q;
          end
          CMD_UPDATE: begin
            addend <= {{(OFF_W-HEIGHT_W){1'b0}}, h_q} - pair_h;
            rptr   <= idx_q + IDX_W'(1);
            wptr   <= idx_q + IDX_W'(1);
          end
          default: begin
            res_off <= base;
            res_h   <= pair_h;
          end
        endcase
      end
      OP_LOOP: begin
        if (rd_more) rptr <= dir_up ? rptr + IDX_W'(1) : rptr - IDX_W'(1);
        if (rd_live) wptr <= dir_up ? wptr + IDX_W'(1) : wptr - IDX_W'(1);
      end
      OP_SRCH_RD: mid_q <= mid;
      OP_SRCH_CMP: begin
        if (go_right) lo <= mid_q + IDX_W'(1);
        else hi <= mid_q;
      end
      OP_S1_END: begin
        if (stat.srch_hit) begin
          res_first <= hit_first;
          lo        <= '0;
          hi        <= items_p1;
          key       <= re_q;
          strict    <= 1'b0;
        end
      end
      OP_S2_END: begin
        if (lo == items_p1) res_cnt <= items - res_first;
        else if (lo <= res_first) res_cnt <= IDX_W'(1);
        else res_cnt <= lo - res_first;
      end
      OP_DIV_STEP: begin
        if (div_cnt != '0) begin
          div_rem <= r2_ge ? HEIGHT_W'(r2 - {1'b0, fixed_height}) : r2[HEIGHT_W-1:0];
          div_q   <= {div_q[DIV_STEPS-2:0], r2_ge};
        end
      end
      OP_DIV_MID: begin
        bi      <= div_q[OFF_W-1:0];
        div_rem <= '0;
        div_q   <= dividend2;
      end
      OP_DIV_END: begin
        if (bi < {{(OFF_W-IDX_W){1'b0}}, items}) begin
          res_first <= bi[IDX_W-1:0];
          if (div_q == {1'b0, bi}) res_cnt <= IDX_W'(1);
          else if (div_q >= {{(DIV_STEPS-IDX_W){1'b0}}, items})
            res_cnt <= items - bi[IDX_W-1:0];
          else res_cnt <= div_q[IDX_W-1:0] - bi[IDX_W-1:0];
        end
      end
      OP_TOT_CAP: begin
        res_total <= variable_mode ? rd_val
                   : {{(OFF_W-HEIGHT_W-IDX_W){1'b0}}, items_prod};
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_data <= {{(OUT_W-OUT_BITS){1'b0}}, res_total, res_cnt, res_first,
                   res_h, res_off, res_status};
    end
  end

endmodule
`default_nettype wire

// File: rtl/iopt_ctrl.sv
// Controller: sequences each command through the datapath and owns the handshakes.
`default_nettype none
module iopt_ctrl import iopt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_PAIR0, S_PAIR1, S_PAIR_END, S_LOOP,
    S_S1_RD, S_S1_CMP, S_S1_END, S_S2_RD, S_S2_CMP, S_S2_END,
    S_DIV1, S_DIV_MID, S_DIV2, S_DIV_END, S_TOT_RD, S_TOT_CAP, S_DONE
  } state_t;

  state_t state, state_next;
  logic   emit;

  assign in_ready = state == S_IDLE;
  assign emit     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd.emit   = emit;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.op     = OP_LOAD;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.op = OP_EXEC;
        case (stat.path)
          PATH_INS:  state_next = S_LOOP;
          PATH_PAIR: state_next = S_PAIR0;
          PATH_SRCH: state_next = S_S1_RD;
          PATH_DIV:  state_next = S_DIV1;
          default:   state_next = S_TOT_RD;
        endcase
      end
      S_PAIR0: begin
        cmd.op     = OP_PAIR0;
        state_next = S_PAIR1;
      end
      S_PAIR1: begin
        cmd.op     = OP_PAIR1;
        state_next = S_PAIR_END;
      end
      S_PAIR_END: begin
        cmd.op     = OP_PAIR_END;
        state_next = stat.pair_loop ? S_LOOP : S_TOT_RD;
      end
      S_LOOP: begin
        cmd.op = OP_LOOP;
        if (stat.loop_done) state_next = S_TOT_RD;
      end
      S_S1_RD: begin
        cmd.op     = OP_SRCH_RD;
        state_next = stat.srch_more ? S_S1_CMP : S_S1_END;
      end
      S_S1_CMP: begin
        cmd.op     = OP_SRCH_CMP;
        state_next = S_S1_RD;
      end
      S_S1_END: begin
        cmd.op     = OP_S1_END;
        state_next = stat.srch_hit ? S_S2_RD : S_TOT_RD;
      end
      S_S2_RD: begin
        cmd.op     = OP_SRCH_RD;
        state_next = stat.srch_more ? S_S2_CMP : S_S2_END;
      end
      S_S2_CMP: begin
        cmd.op     = OP_SRCH_CMP;
        state_next = S_S2_RD;
      end
      S_S2_END: begin
        cmd.op     = OP_S2_END;
        state_next = S_TOT_RD;
      end
      S_DIV1: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_done) state_next = S_DIV_MID;
      end
      S_DIV_MID: begin
        cmd.op     = OP_DIV_MID;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_done) state_next = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.op     = OP_DIV_END;
        state_next = S_TOT_RD;
      end
      S_TOT_RD: begin
        cmd.op     = OP_TOT_RD;
        state_next = S_TOT_CAP;
      end
      S_TOT_CAP: begin
        cmd.op     = OP_TOT_CAP;
        state_next = S_DONE;
      end
      S_DONE: if (emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/item_offset_prefix_table.sv
// Top level of the item offset prefix table.
//
// One command transaction on the s_axis side gives exactly one result transaction
// on the m_axis side. Commands: clear, insert, remove, update height, query item,
// query visible range, query total. The cfg channel writes variable_mode (index 0)
// and fixed_height (index 1); it is always ready and is meant for idle periods.
// One command is worked at a time; s_axis_tready is high only while idle.
// The work from acceptance to result valid depends on the command:
//   clear, total, fixed-mode commands, errors: no table walk, only the total read
//   query item in variable mode: reads of the item's two offset entries
//   insert: a walk down to the index, one entry shifted per cycle
//   remove, update: a pair read, then a walk of the entries above the index
//   variable range: two binary searches (the second only when the first hits)
//   fixed range: two 33-step serial divisions
// The result sits in an output register; the next command is accepted while it
// waits, and a stalled receiver only holds the controller at its final step.
// Reset clears the item count and variable_mode and sets fixed_height to 16; table entry zero
// always reads as zero and needs no clearing pass.
`default_nettype none
module item_offset_prefix_table import iopt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // command, item_index, item_span, new_height, range_begin, range_end
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status, item_offset, item_height, first_visible, visible_count, total_height
  output logic [OUT_W-1:0]           m_axis_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  iopt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iopt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire
